// ===== design/mm5_pkg.sv =====
// Shared types, constants and helpers for the 5x5 row-wise matrix multiplier.
package mm5_pkg;

	localparam int DIM       = 5;
	localparam int FRAC_BITS = 16;
	localparam int ELEM_W    = 32;
	localparam int ROW_W     = 3;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int SUM_W     = PROD_W + $clog2(DIM);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_MUL  = 1'b1
	} opcode_t;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	typedef elem_t [DIM-1:0]             row_t;
	typedef row_t  [DIM-1:0]             matrix_t;
	typedef prod_t [DIM-1:0][DIM-1:0]    prod_mat_t;
	typedef sum_t  [DIM-1:0]             sum_row_t;

	typedef struct packed {
		opcode_t           opcode;
		logic [ROW_W-1:0]  row_index;
		elem_t             elem_4;
		elem_t             elem_3;
		elem_t             elem_2;
		elem_t             elem_1;
		elem_t             elem_0;
	} in_word_t;

	typedef struct packed {
		logic [ROW_W-1:0]  out_row;
		elem_t             prod_4;
		elem_t             prod_3;
		elem_t             prod_2;
		elem_t             prod_1;
		elem_t             prod_0;
		logic              saturated;
	} out_word_t;

	typedef struct packed {
		logic              vld;
		logic [ROW_W-1:0]  row;
	} ctl_t;

	function automatic row_t in_row(in_word_t w);
		row_t r;
		r[0] = w.elem_0;
		r[1] = w.elem_1;
		r[2] = w.elem_2;
		r[3] = w.elem_3;
		r[4] = w.elem_4;
		return r;
	endfunction

endpackage

// ===== design/matrix_multiply_5x5_rowwise.sv =====
// Top level of the row-wise 5x5 Q16.16 matrix multiplier.
//
// Input channel item/item_valid/item_stall carries one word per row. A load
// word (opcode OP_LOAD) writes row row_index of the stored matrix B and gives
// no result. A multiply word (OP_MUL) carries row row_index of A and yields
// one result word on result/result_valid/result_stall: that row of A x B,
// each element shifted right by 16 and saturated to 32 bits. Words with a
// row index of 5 or more are taken and dropped.
// The accepting edge loads the input register; the word then moves through
// the product, column sum and result registers in that order.
// The pipeline takes one word every cycle unless result_stall freezes it.
// A load takes effect on the edge it is accepted, so a multiply word that
// follows it in the next cycle already uses the new row.
// Reset clears the pipeline and sets all of B to zero.
// While result_stall holds a waiting result, the whole pipeline freezes and
// item_stall is raised in the same cycle; nothing is lost or repeated.
module matrix_multiply_5x5_rowwise import mm5_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_word_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_word_t result
);

	logic      en;
	logic      row_ok;
	logic      load_we;
	ctl_t      ctl_s1;
	ctl_t      ctl_s2;
	ctl_t      ctl_s3;
	row_t      a_s1;
	matrix_t   b_q;
	prod_mat_t prod_s2;
	sum_row_t  sum_s3;

	assign en         = !result_valid || !result_stall;
	assign item_stall = !en;
	assign row_ok     = item.row_index < ROW_W'(DIM);
	assign load_we    = item_valid && en && item.opcode == OP_LOAD && row_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.vld <= item_valid && item.opcode == OP_MUL && row_ok;
			ctl_s1.row <= item.row_index;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= in_row(item);
		end
	end

	mm5_bstore u_bstore (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (load_we),
		.wrow   (item.row_index),
		.wdata  (in_row(item)),
		.b_q    (b_q)
	);

	mm5_prod u_prod (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_s1  (ctl_s1),
		.a_s1    (a_s1),
		.b       (b_q),
		.ctl_s2  (ctl_s2),
		.prod_s2 (prod_s2)
	);

	mm5_sum u_sum (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_s2  (ctl_s2),
		.prod_s2 (prod_s2),
		.ctl_s3  (ctl_s3),
		.sum_s3  (sum_s3)
	);

	mm5_sat u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_s3    (ctl_s3),
		.sum_s3    (sum_s3),
		.out_vld_q (result_valid),
		.out_q     (result)
	);

endmodule

// ===== design/mm5_bstore.sv =====
// Storage of the right-hand matrix B, written one row per load word.
module mm5_bstore import mm5_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [ROW_W-1:0] wrow,
	input  row_t             wdata,
	output matrix_t          b_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
		end else begin
			for (int r = 0; r < DIM; r++) begin
				if (we && wrow == ROW_W'(r)) begin
					b_q[r] <= wdata;
				end
			end
		end
	end

endmodule

// ===== design/mm5_prod.sv =====
// Product stage: all DIM x DIM element products of the A row with B, registered.
module mm5_prod import mm5_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  ctl_t      ctl_s1,
	input  row_t      a_s1,
	input  matrix_t   b,
	output ctl_t      ctl_s2,
	output prod_mat_t prod_s2
);

	prod_mat_t prod;

	always_comb begin
		for (int k = 0; k < DIM; k++) begin
			for (int j = 0; j < DIM; j++) begin
				prod[k][j] = prod_t'(a_s1[k]) * prod_t'(b[k][j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod;
		end
	end

endmodule

// ===== design/mm5_sum.sv =====
// Column sum stage: exact sum of the DIM products of each column, registered.
module mm5_sum import mm5_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  ctl_t      ctl_s2,
	input  prod_mat_t prod_s2,
	output ctl_t      ctl_s3,
	output sum_row_t  sum_s3
);

	sum_row_t sum;

	always_comb begin
		for (int j = 0; j < DIM; j++) begin
			sum[j] = '0;
			for (int k = 0; k < DIM; k++) begin
				sum[j] = sum[j] + sum_t'(prod_s2[k][j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sum;
		end
	end

endmodule

// ===== design/mm5_sat.sv =====
// Output stage: fixed-point shift, saturation and the result register.
module mm5_sat import mm5_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  ctl_t      ctl_s3,
	input  sum_row_t  sum_s3,
	output logic      out_vld_q,
	output out_word_t out_q
);

	localparam elem_t POS_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam elem_t NEG_MAX = {1'b1, {(ELEM_W-1){1'b0}}};

	sum_row_t  shifted;
	row_t      val;
	logic [DIM-1:0] clip;
	out_word_t nxt;

	always_comb begin
		for (int j = 0; j < DIM; j++) begin
			// arithmetic shift floors toward minus infinity
			shifted[j] = sum_s3[j] >>> FRAC_BITS;
			clip[j] = !(&shifted[j][SUM_W-1:ELEM_W-1] || ~|shifted[j][SUM_W-1:ELEM_W-1]);
			if (clip[j]) begin
				val[j] = shifted[j][SUM_W-1] ? NEG_MAX : POS_MAX;
			end else begin
				val[j] = shifted[j][ELEM_W-1:0];
			end
		end
		nxt.out_row   = ctl_s3.row;
		nxt.prod_0    = val[0];
		nxt.prod_1    = val[1];
		nxt.prod_2    = val[2];
		nxt.prod_3    = val[3];
		nxt.prod_4    = val[4];
		nxt.saturated = |clip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= ctl_s3.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= nxt;
		end
	end

endmodule
